FILE: rtl/tkls_pkg.sv
// ----------------------------------------------------------------------------
// tkls_pkg
// Shared widths and types of the top-k largest selector.
// ----------------------------------------------------------------------------
package tkls_pkg;

    localparam int SIZE_W  = 48;
    localparam int IDENT_W = 16;
    localparam int POS_W   = 4;

    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [IDENT_W-1:0] ident;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic clear;
    } t_store_ctrl;

endpackage

FILE: rtl/tkls_if.sv
// ----------------------------------------------------------------------------
// tkls_item_if / tkls_rank_if
// Valid/ready channels for incoming items and outgoing ranked entries.
// ----------------------------------------------------------------------------
interface tkls_item_if;
    import tkls_pkg::*;

    logic               valid;
    logic               ready;
    logic               item_present;
    logic [SIZE_W-1:0]  item_size;
    logic [IDENT_W-1:0] item_ident;
    logic               end_of_scan;

    modport source (
        output valid, item_present, item_size, item_ident, end_of_scan,
        input  ready
    );
    modport sink (
        input  valid, item_present, item_size, item_ident, end_of_scan,
        output ready
    );
endinterface

interface tkls_rank_if;
    import tkls_pkg::*;

    logic               valid;
    logic               ready;
    logic [SIZE_W-1:0]  rank_size;
    logic [IDENT_W-1:0] rank_ident;
    logic [POS_W-1:0]   rank_position;
    logic               final_entry;

    modport source (
        output valid, rank_size, rank_ident, rank_position, final_entry,
        input  ready
    );
    modport sink (
        input  valid, rank_size, rank_ident, rank_position, final_entry,
        output ready
    );
endinterface

FILE: rtl/tkls_store.sv
// ----------------------------------------------------------------------------
// tkls_store
// Sorted register file with parallel compare-insert.
// ----------------------------------------------------------------------------
module tkls_store #(
    parameter int TOP_COUNT = 10
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  tkls_pkg::t_store_ctrl                    i_ctrl,
    input  logic [tkls_pkg::SIZE_W-1:0]              i_size,
    input  logic [tkls_pkg::IDENT_W-1:0]             i_ident,
    output tkls_pkg::t_entry [TOP_COUNT-1:0]         o_next,
    output logic [$clog2(TOP_COUNT+1)-1:0]           o_next_count
);
    import tkls_pkg::*;

    localparam int CW = $clog2(TOP_COUNT+1);

    t_entry [TOP_COUNT-1:0] r_entry;
    t_entry [TOP_COUNT-1:0] n_entry;
    logic   [CW-1:0]        r_count;
    logic   [CW-1:0]        n_count;
    logic   [TOP_COUNT-1:0] ge;
    logic                   do_ins;
    t_entry                 new_entry;

    always_comb begin
        new_entry.size  = i_size;
        new_entry.ident = i_ident;
        // entries at or above the new size form a prefix
        for (int i = 0; i < TOP_COUNT; i++) begin
            ge[i] = (CW'(i) < r_count) && (r_entry[i].size >= i_size);
        end
        do_ins = i_ctrl.insert &&
                 ((r_count != CW'(TOP_COUNT)) || (i_size > r_entry[TOP_COUNT-1].size));
        n_entry = r_entry;
        if (do_ins && !ge[0]) begin
            n_entry[0] = new_entry;
        end
        for (int i = 1; i < TOP_COUNT; i++) begin
            if (do_ins && !ge[i]) begin
                n_entry[i] = ge[i-1] ? new_entry : r_entry[i-1];
            end
        end
        n_count = (do_ins && (r_count != CW'(TOP_COUNT))) ? r_count + CW'(1) : r_count;
    end

    assign o_next       = n_entry;
    assign o_next_count = n_count;

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.clear) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

FILE: rtl/top_k_largest_selector_unit.sv
// ----------------------------------------------------------------------------
// top_k_largest_selector_unit
// Keeps the TOP_COUNT largest items of a stream and emits them on end of scan.
// ----------------------------------------------------------------------------
// One request is taken per cycle while no ranking is being sent: each entry is
// merged into a sorted register file by a parallel compare-insert in the cycle
// it is accepted. A request with end_of_scan copies the updated ranking into a
// send buffer and clears the store; the buffer then sends one entry per cycle
// while the output is not held off, largest first, and input stays stalled
// until every entry of it has moved to the output register.
// Equal sizes keep arrival order. rank_position carries the low 4 bits.
module top_k_largest_selector_unit #(
    parameter int TOP_COUNT = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tkls_item_if.sink   i_item,
    tkls_rank_if.source o_rank
);
    import tkls_pkg::*;

    localparam int CW = $clog2(TOP_COUNT+1);

    t_store_ctrl            store_ctrl;
    t_entry [TOP_COUNT-1:0] next_entry;
    logic   [CW-1:0]        next_count;
    logic                   in_take;
    logic                   out_load;
    logic [CW+POS_W-1:0]    pos_ext;

    t_entry [TOP_COUNT-1:0] r_emit;
    logic   [CW-1:0]        r_left;
    logic   [CW-1:0]        r_pos;
    logic                   r_out_valid;
    t_entry                 r_out_entry;
    logic   [POS_W-1:0]     r_out_pos;
    logic                   r_out_final;

    assign i_item.ready      = (r_left == '0);
    assign in_take           = i_item.valid && i_item.ready;
    assign store_ctrl.insert = in_take && i_item.item_present;
    assign store_ctrl.clear  = in_take && i_item.end_of_scan;
    assign out_load          = (r_left != '0) && (!r_out_valid || o_rank.ready);
    assign pos_ext           = {{POS_W{1'b0}}, r_pos};

    tkls_store #(
        .TOP_COUNT (TOP_COUNT)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (store_ctrl),
        .i_size       (i_item.item_size),
        .i_ident      (i_item.item_ident),
        .o_next       (next_entry),
        .o_next_count (next_count)
    );

    // send buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_pos  <= '0;
        end else if (store_ctrl.clear) begin
            r_emit <= next_entry;
            r_left <= next_count;
            r_pos  <= '0;
        end else if (out_load) begin
            for (int i = 0; i < TOP_COUNT - 1; i++) begin
                r_emit[i] <= r_emit[i+1];
            end
            r_left <= r_left - CW'(1);
            r_pos  <= r_pos + CW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
            r_out_entry <= r_emit[0];
            r_out_pos   <= pos_ext[POS_W-1:0];
            r_out_final <= (r_left == CW'(1));
        end else if (o_rank.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rank.valid         = r_out_valid;
    assign o_rank.rank_size     = r_out_entry.size;
    assign o_rank.rank_ident    = r_out_entry.ident;
    assign o_rank.rank_position = r_out_pos;
    assign o_rank.final_entry   = r_out_final;

endmodule

FILE: rtl/tkls_checker.sv
// ----------------------------------------------------------------------------
// tkls_checker
// Port-level checks of the top-k largest selector.
// ----------------------------------------------------------------------------
module tkls_checker #(
    parameter int TOP_COUNT = 10
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_item_ready,
    input logic       o_rank_valid,
    input logic       o_rank_ready,
    input logic [3:0] o_rank_position,
    input logic       o_rank_final_entry
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rank_valid && !o_rank_ready |=> o_rank_valid)
        else $error("result dropped while stalled");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rank_valid)
        else $error("result valid after reset");

    // a ranking in progress blocks new requests
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rank_valid && !o_rank_final_entry |-> !i_item_ready)
        else $error("request accepted during ranking");

    // rank position stays below TOP_COUNT unless TOP_COUNT exceeds 16
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rank_valid |-> (TOP_COUNT > 16) || (int'(o_rank_position) < TOP_COUNT))
        else $error("rank position out of range");

endmodule

bind top_k_largest_selector_unit tkls_checker #(
    .TOP_COUNT (TOP_COUNT)
) u_tkls_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_item_ready       (i_item.ready),
    .o_rank_valid       (o_rank.valid),
    .o_rank_ready       (o_rank.ready),
    .o_rank_position    (o_rank.rank_position),
    .o_rank_final_entry (o_rank.final_entry)
);

FILE: bench/top_k_largest_selector_unit_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_largest_selector_unit_check
// Watches both channels of the top-k selector, keeps its own sorted store of
// the largest entries, and checks every ranked entry that leaves the block
// against the ranking predicted when the end-of-scan request went in.
// ----------------------------------------------------------------------------
module top_k_largest_selector_unit_check #(
    parameter int TOP_COUNT = 10
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tkls_item_if  i_item,
    tkls_rank_if  i_rank,
    output int    o_fail_count,
    output int    o_pending
);
    import tkls_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_entry           entry;
        logic [POS_W-1:0] position;
        logic             final_entry;
    } t_ranked;

    t_entry  kept_entries [TOP_COUNT];
    int      held_count = 0;
    t_ranked ranking_q [$];
    int      mismatches = 0;

    assign o_fail_count = mismatches;

    // earlier arrivals stay ahead of later ones of the same size
    function automatic void merge_entry(t_entry arriving);
        int slot;
        if (held_count >= TOP_COUNT) begin
            if (arriving.size <= kept_entries[TOP_COUNT-1].size)
                return;
            held_count = TOP_COUNT - 1;
        end
        slot = 0;
        while (slot < held_count && kept_entries[slot].size >= arriving.size)
            slot++;
        for (int j = held_count; j > slot; j--)
            kept_entries[j] = kept_entries[j-1];
        kept_entries[slot] = arriving;
        held_count++;
    endfunction

    function automatic void emit_ranking();
        t_ranked ranked;
        for (int k = 0; k < held_count; k++) begin
            ranked.entry       = kept_entries[k];
            ranked.position    = POS_W'(k);
            ranked.final_entry = (k == held_count - 1);
            ranking_q = {ranking_q, ranked};
        end
        held_count = 0;
    endfunction

    function automatic void check_ranked_entry();
        t_ranked want;
        if (ranking_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("unexpected ranked entry: size %0d ident %h position %0d final %b",
                         i_rank.rank_size, i_rank.rank_ident, i_rank.rank_position,
                         i_rank.final_entry);
            return;
        end
        want = ranking_q.pop_front();
        if (i_rank.rank_size !== want.entry.size || i_rank.rank_ident !== want.entry.ident
                || i_rank.rank_position !== want.position
                || i_rank.final_entry !== want.final_entry) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("ranked entry mismatch: expected size %0d ident %h position %0d final %b",
                         want.entry.size, want.entry.ident, want.position, want.final_entry);
                $display("                       actual   size %0d ident %h position %0d final %b",
                         i_rank.rank_size, i_rank.rank_ident, i_rank.rank_position,
                         i_rank.final_entry);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            ranking_q.delete();
        end else begin
            if (i_item.valid && i_item.ready) begin
                if (i_item.item_present)
                    merge_entry({i_item.item_size, i_item.item_ident});
                if (i_item.end_of_scan)
                    emit_ranking();
            end
            if (i_rank.valid && i_rank.ready)
                check_ranked_entry();
        end
        o_pending <= ranking_q.size();
    end

endmodule

FILE: bench/top_k_largest_selector_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_largest_selector_unit_test
// Drives scans of sized entries into the top-k selector: directed cases for
// ties, full-store rejection and empty ends, then random scans with bursty
// idling on both channels and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module top_k_largest_selector_unit_test;
    import tkls_pkg::*;

    localparam int TOP_COUNT   = 10;
    localparam int ITEM_TARGET = 330;
    localparam int CALM_FROM   = 290;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bit calm          = 1'b0;
    int hold_requests = 0;
    int holds_granted = 0;
    int hold_left     = 0;
    int stall_left    = 0;
    int items_sent    = 0;
    int cycle_count   = 0;
    int fail_count;
    int pending;

    tkls_item_if item_ch ();
    tkls_rank_if rank_ch ();

    top_k_largest_selector_unit #(
        .TOP_COUNT (TOP_COUNT)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_rank  (rank_ch)
    );

    top_k_largest_selector_unit_check #(
        .TOP_COUNT (TOP_COUNT)
    ) ranking_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_rank       (rank_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // output side: random stall bursts plus the long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rank_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            rank_ch.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (holds_granted != hold_requests) begin
            holds_granted <= holds_granted + 1;
            hold_left     <= LONG_HOLD;
            rank_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            rank_ch.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            rank_ch.ready <= 1'b0;
            stall_left    <= $urandom_range(0, 12);
        end else begin
            rank_ch.ready <= 1'b1;
        end
    end

    function automatic logic [SIZE_W-1:0] pick_size(input int kind);
        logic [63:0] wide;
        int          mode;
        wide = {$urandom, $urandom};
        mode = (kind == 3) ? $urandom_range(0, 2) : kind;
        case (mode)
            0:       return SIZE_W'($urandom_range(0, 15));
            1:       return wide[SIZE_W-1:0];
            default: return SIZE_MAX - SIZE_W'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic send_item(input logic present, input logic [SIZE_W-1:0] size,
                             input logic [IDENT_W-1:0] ident, input logic at_end);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.item_present <= present;
        item_ch.item_size    <= size;
        item_ch.item_ident   <= ident;
        item_ch.end_of_scan  <= at_end;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        if (present || at_end)
            items_sent++;
    endtask

    task automatic send_scan(input int length, input int kind);
        for (int n = 0; n < length; n++) begin
            if ($urandom_range(0, 11) == 0)
                send_item(1'b0, pick_size(1), IDENT_W'($urandom), 1'b0);
            send_item(1'b1, pick_size(kind), IDENT_W'($urandom), 1'b0);
        end
        send_item(1'($urandom_range(0, 1)), pick_size(kind), IDENT_W'($urandom), 1'b1);
    endtask

    task automatic wait_for_rankings();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        bit paused;
        int length;
        paused = 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.item_present <= 1'b0;
        item_ch.item_size    <= '0;
        item_ch.item_ident   <= '0;
        item_ch.end_of_scan  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // end on an empty store, bare marker with junk payload
        send_item(1'b0, SIZE_MAX, '1, 1'b1);
        send_item(1'b0, SIZE_MAX, '1, 1'b0);
        // single entry ranking
        send_item(1'b1, 48'd42, 16'h0001, 1'b1);
        // extremes and ties, closed by an end carrying an entry
        send_item(1'b1, '0, '0, 1'b0);
        send_item(1'b1, SIZE_MAX, '1, 1'b0);
        send_item(1'b1, 48'd5, 16'h0001, 1'b0);
        send_item(1'b1, 48'd5, 16'h0002, 1'b0);
        send_item(1'b1, 48'd5, 16'h0003, 1'b0);
        send_item(1'b1, 48'd5, 16'h0004, 1'b1);
        // full store: equal and smaller rejected, larger drops the latest tie
        for (int n = 0; n < 7; n++)
            send_item(1'b1, 48'd1000 - 48'(n * 100), 16'(16'h0100 + n), 1'b0);
        send_item(1'b1, 48'd7, 16'h0011, 1'b0);
        send_item(1'b1, 48'd7, 16'h0012, 1'b0);
        send_item(1'b1, 48'd7, 16'h0013, 1'b0);
        send_item(1'b1, 48'd7, 16'h0014, 1'b0);
        send_item(1'b1, 48'd3, 16'h0015, 1'b0);
        send_item(1'b1, 48'd8, 16'h0016, 1'b0);
        send_item(1'b0, 48'd9, 16'h0017, 1'b1);
        wait_for_rankings();

        // output held off while full scans keep coming
        hold_requests <= hold_requests + 1;
        send_scan(12, 1);
        send_scan(12, 3);

        while (items_sent < ITEM_TARGET) begin
            calm = (items_sent >= CALM_FROM) || ($urandom_range(0, 5) == 0);
            if (!paused && items_sent > 180) begin
                paused = 1'b1;
                wait_for_rankings();
            end
            length = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4)
                                                 : $urandom_range(5, 24);
            send_scan(length, $urandom_range(0, 3));
        end

        wait_for_rankings();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
